// File: rtl/wavhp_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the wav header parser
// no dependencies; used by all rtl modules

package wavhp_pkg;

  // tags as little-endian words
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_BYTES  = 32'd16;
  localparam logic [15:0] BITS_16    = 16'd16;

  // divider steps, one quotient bit each
  localparam int DIV_STEPS = 31;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

  // result kinds
  localparam logic [1:0] KIND_FORMAT = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_TAG  = 3'd1;
  localparam logic [2:0] ST_NO_FMT   = 3'd2;
  localparam logic [2:0] ST_NOT_16   = 3'd3;
  localparam logic [2:0] ST_NO_DATA  = 3'd4;
  localparam logic [2:0] ST_SHORT    = 3'd5;

  // result descriptor pushed by the controller
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] status;
    logic       last;
  } desc_t;

  // queued result slot
  typedef struct packed {
    desc_t       desc;
    logic [15:0] sample;
  } slot_t;

  // controller to datapath commands
  typedef struct packed {
    logic       shift_en;
    logic       load_chunk;
    logic       load_data;
    logic       load_skip_word;
    logic       load_skip_extra;
    logic       dec_skip;
    logic       dec_data;
    logic       fmt_wr;
    logic [3:0] fmt_idx;
    logic       low_wr;
    logic       div_start;
    logic       push_a;
    desc_t      desc_a;
    logic       push_b;
    desc_t      desc_b;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_riff;
    logic is_wave;
    logic is_fmt;
    logic is_data;
    logic word_zero;
    logic skip_last;
    logic data_last;
    logic chunk_gt16;
    logic bits16;
    logic bits_now16;
    logic q_empty;
    logic div_busy;
  } sts_t;

endpackage

// File: rtl/wavhp_div.sv
`timescale 1ns / 1ps
// iterative restoring divider for the frame count, one quotient bit a cycle
// depends on wavhp_pkg

module wavhp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [30:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [30:0] quotient
);

  logic [wavhp_pkg::DIV_CW-1:0] cnt_r;
  logic [15:0] rem_r;
  logic [30:0] quo_r;
  logic [15:0] dsr_r;
  logic [16:0] trial;
  logic [17:0] diff;

  // trial subtraction of the divisor from the shifted remainder
  always_comb begin
    trial = {rem_r, quo_r[30]};
    diff  = {1'b0, trial} - {2'b00, dsr_r};
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= wavhp_pkg::DIV_CW'(wavhp_pkg::DIV_STEPS);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (cnt_r != '0) begin
      if (!diff[17]) begin
        rem_r <= diff[15:0];
        quo_r <= {quo_r[29:0], 1'b1};
      end else begin
        rem_r <= trial[15:0];
        quo_r <= {quo_r[29:0], 1'b0};
      end
    end
  end

  assign busy     = (cnt_r != '0);
  assign quotient = (dsr_r == 16'd0) ? 31'd0 : quo_r;

endmodule

// File: rtl/wavhp_datapath.sv
`timescale 1ns / 1ps
// datapath: word shifter, chunk counters, fmt field holds, result queue
// depends on wavhp_pkg and wavhp_div

module wavhp_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           data_byte,
  input  wavhp_pkg::cmd_t      cmd,
  output wavhp_pkg::sts_t      sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_result_kind,
  output logic [2:0]           out_status_code,
  output logic [15:0]          out_audio_format,
  output logic [15:0]          out_channel_count,
  output logic [31:0]          out_sample_rate,
  output logic [31:0]          out_byte_rate,
  output logic [15:0]          out_block_align,
  output logic [15:0]          out_sample_bits,
  output logic [31:0]          out_data_length,
  output logic [30:0]          out_frame_count,
  output logic signed [15:0]   out_sample_value,
  output logic                 out_last_result
);

  logic [31:0] tag_r;
  logic [31:0] chunk_r;
  logic [31:0] skip_r;
  logic [31:0] data_r;
  logic [7:0]  low_r;
  logic [15:0] fmt_r;
  logic [15:0] chan_r;
  logic [31:0] rate_r;
  logic [31:0] brate_r;
  logic [15:0] align_r;
  logic [15:0] bits_r;
  logic [31:0] new_word;

  wavhp_pkg::slot_t q0_r, q1_r;
  wavhp_pkg::slot_t slot_a, slot_b;
  logic [1:0] q_cnt_r;
  logic       pop;
  logic       div_busy;
  logic [30:0] div_quo;

  // little-endian word with the current byte on top
  assign new_word = {data_byte, tag_r[31:8]};

  // status toward the controller
  always_comb begin
    sts.is_riff    = (new_word == wavhp_pkg::TAG_RIFF);
    sts.is_wave    = (new_word == wavhp_pkg::TAG_WAVE);
    sts.is_fmt     = (new_word == wavhp_pkg::TAG_FMT);
    sts.is_data    = (new_word == wavhp_pkg::TAG_DATA);
    sts.word_zero  = (new_word == 32'd0);
    sts.skip_last  = (skip_r == 32'd1);
    sts.data_last  = (data_r == 32'd1);
    sts.chunk_gt16 = (chunk_r > wavhp_pkg::FMT_BYTES);
    sts.bits16     = (bits_r == wavhp_pkg::BITS_16);
    sts.bits_now16 = ({data_byte, bits_r[7:0]} == wavhp_pkg::BITS_16);
    sts.q_empty    = (q_cnt_r == 2'd0);
    sts.div_busy   = div_busy;
  end

  // word shifter, counters and length registers
  always_ff @(posedge clk) begin
    if (cmd.shift_en) tag_r <= new_word;
    if (cmd.load_chunk) chunk_r <= new_word;
    if (cmd.load_data) begin
      data_r <= new_word;
    end else if (cmd.dec_data) begin
      data_r <= data_r - 32'd1;
    end
    if (cmd.load_skip_word) begin
      skip_r <= new_word;
    end else if (cmd.load_skip_extra) begin
      skip_r <= chunk_r - wavhp_pkg::FMT_BYTES;
    end else if (cmd.dec_skip) begin
      skip_r <= skip_r - 32'd1;
    end
    if (cmd.low_wr) low_r <= data_byte;
  end

  // fmt field capture, each byte written once per file
  always_ff @(posedge clk) begin
    if (cmd.fmt_wr) begin
      case (cmd.fmt_idx) inside
        4'd0, 4'd1:             fmt_r[{cmd.fmt_idx[0], 3'b000} +: 8] <= data_byte;
        4'd2, 4'd3:             chan_r[{cmd.fmt_idx[0], 3'b000} +: 8] <= data_byte;
        [4'd4:4'd7]:            rate_r[{cmd.fmt_idx[1:0], 3'b000} +: 8] <= data_byte;
        [4'd8:4'd11]:           brate_r[{cmd.fmt_idx[1:0], 3'b000} +: 8] <= data_byte;
        4'd12, 4'd13:           align_r[{cmd.fmt_idx[0], 3'b000} +: 8] <= data_byte;
        default:                bits_r[{cmd.fmt_idx[0], 3'b000} +: 8] <= data_byte;
      endcase
    end
  end

  // frame count divider
  wavhp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (new_word[31:1]),
    .divisor  (chan_r),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // slots built from the pushed descriptors
  always_comb begin
    slot_a.desc   = cmd.desc_a;
    slot_a.sample = (cmd.desc_a.kind == wavhp_pkg::KIND_SAMPLE) ?
                    {data_byte, low_r} : 16'd0;
    slot_b.desc   = cmd.desc_b;
    slot_b.sample = 16'd0;
  end

  // two-slot result queue, filled only when empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
    end else if (cmd.push_a || cmd.push_b) begin
      q_cnt_r <= {1'b0, cmd.push_a} + {1'b0, cmd.push_b};
    end else if (pop) begin
      q_cnt_r <= q_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_a) begin
      q0_r <= slot_a;
      q1_r <= slot_b;
    end else if (cmd.push_b) begin
      q0_r <= slot_b;
    end else if (pop) begin
      q0_r <= q1_r;
    end
  end

  // head of queue drives the result channel; format waits for the divide
  assign out_valid = (q_cnt_r != 2'd0) &&
                     !((q0_r.desc.kind == wavhp_pkg::KIND_FORMAT) && div_busy);
  assign pop       = out_valid && out_ready;

  always_comb begin
    logic is_fmt_res;
    is_fmt_res        = (q0_r.desc.kind == wavhp_pkg::KIND_FORMAT);
    out_result_kind   = q0_r.desc.kind;
    out_status_code   = q0_r.desc.status;
    out_last_result   = q0_r.desc.last;
    out_sample_value  = q0_r.sample;
    out_audio_format  = is_fmt_res ? fmt_r   : 16'd0;
    out_channel_count = is_fmt_res ? chan_r  : 16'd0;
    out_sample_rate   = is_fmt_res ? rate_r  : 32'd0;
    out_byte_rate     = is_fmt_res ? brate_r : 32'd0;
    out_block_align   = is_fmt_res ? align_r : 16'd0;
    out_sample_bits   = is_fmt_res ? bits_r  : 16'd0;
    out_data_length   = is_fmt_res ? chunk_r : 32'd0;
    out_frame_count   = is_fmt_res ? div_quo : 31'd0;
  end

  // queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r != 2'd3)
    else $error("result queue count out of range");

  // pushes land only in an empty queue
  a_push_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_a || cmd.push_b) |-> (q_cnt_r == 2'd0))
    else $error("push into non-empty queue");

  // a divide is never restarted while running
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // a started divide runs before the format item can leave
  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (div_busy && !out_valid))
    else $error("format item shown before divide done");

endmodule

// File: rtl/wavhp_ctrl.sv
`timescale 1ns / 1ps
// controller: parse phase state machine and byte counter
// depends on wavhp_pkg; drives commands to wavhp_datapath

module wavhp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_end_of_file,
  input  wavhp_pkg::sts_t sts,
  output wavhp_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_FID, PH_FSKIPLEN, PH_FMTLEN, PH_FSKIP,
    PH_FMT, PH_FEXTRA, PH_DID, PH_DSKIPLEN, PH_DATALEN, PH_DSKIP, PH_DATA,
    PH_DONE
  } phase_t;

  phase_t     phase_r, phase_nxt, ph_step;
  logic [3:0] cnt_r, cnt_nxt, cnt_step;
  logic       fire;
  logic       word_done;

  assign in_ready  = sts.q_empty && !sts.div_busy;
  assign fire      = in_valid && in_ready;
  assign word_done = (cnt_r == 4'd3);

  // per-byte phase step and commands
  always_comb begin
    wavhp_pkg::desc_t eof_desc;
    ph_step  = phase_r;
    cnt_step = cnt_r;
    cmd      = '0;
    eof_desc = '0;

    unique case (phase_r)
      PH_RIFF, PH_WAVE, PH_RSIZE, PH_FID, PH_DID, PH_FSKIPLEN, PH_DSKIPLEN,
      PH_FMTLEN, PH_DATALEN: begin
        cmd.shift_en = 1'b1;
        cnt_step     = word_done ? 4'd0 : cnt_r + 4'd1;
        if (word_done) begin
          unique case (phase_r)
            PH_RIFF: begin
              if (sts.is_riff) begin
                ph_step = PH_RSIZE;
              end else begin
                ph_step    = PH_DONE;
                cmd.push_a = 1'b1;
                cmd.desc_a = '{kind: wavhp_pkg::KIND_STATUS,
                               status: wavhp_pkg::ST_BAD_TAG, last: 1'b1};
              end
            end
            PH_WAVE: begin
              if (sts.is_wave) begin
                ph_step = PH_FID;
              end else begin
                ph_step    = PH_DONE;
                cmd.push_a = 1'b1;
                cmd.desc_a = '{kind: wavhp_pkg::KIND_STATUS,
                               status: wavhp_pkg::ST_BAD_TAG, last: 1'b1};
              end
            end
            PH_RSIZE: ph_step = PH_WAVE;
            PH_FID:   ph_step = sts.is_fmt ? PH_FMTLEN : PH_FSKIPLEN;
            PH_DID:   ph_step = sts.is_data ? PH_DATALEN : PH_DSKIPLEN;
            PH_FSKIPLEN: begin
              cmd.load_skip_word = 1'b1;
              ph_step = sts.word_zero ? PH_FID : PH_FSKIP;
            end
            PH_DSKIPLEN: begin
              cmd.load_skip_word = 1'b1;
              ph_step = sts.word_zero ? PH_DID : PH_DSKIP;
            end
            PH_FMTLEN: begin
              cmd.load_chunk = 1'b1;
              ph_step        = PH_FMT;
            end
            default: begin
              // data length word
              cmd.load_chunk = 1'b1;
              cmd.load_data  = 1'b1;
              cmd.div_start  = 1'b1;
              cmd.push_a     = 1'b1;
              cmd.desc_a     = '{kind: wavhp_pkg::KIND_FORMAT,
                                 status: wavhp_pkg::ST_OK, last: sts.word_zero};
              ph_step        = sts.word_zero ? PH_DONE : PH_DATA;
            end
          endcase
        end
      end
      PH_FSKIP, PH_DSKIP: begin
        cmd.dec_skip = 1'b1;
        if (sts.skip_last) ph_step = (phase_r == PH_FSKIP) ? PH_FID : PH_DID;
      end
      PH_FMT: begin
        cmd.fmt_wr  = 1'b1;
        cmd.fmt_idx = cnt_r;
        cnt_step    = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          cnt_step = 4'd0;
          if (sts.chunk_gt16) begin
            cmd.load_skip_extra = 1'b1;
            ph_step             = PH_FEXTRA;
          end else if (sts.bits_now16) begin
            ph_step = PH_DID;
          end else begin
            ph_step    = PH_DONE;
            cmd.push_a = 1'b1;
            cmd.desc_a = '{kind: wavhp_pkg::KIND_STATUS,
                           status: wavhp_pkg::ST_NOT_16, last: 1'b1};
          end
        end
      end
      PH_FEXTRA: begin
        cmd.dec_skip = 1'b1;
        if (sts.skip_last) begin
          if (sts.bits16) begin
            ph_step = PH_DID;
          end else begin
            ph_step    = PH_DONE;
            cmd.push_a = 1'b1;
            cmd.desc_a = '{kind: wavhp_pkg::KIND_STATUS,
                           status: wavhp_pkg::ST_NOT_16, last: 1'b1};
          end
        end
      end
      PH_DATA: begin
        cmd.dec_data = 1'b1;
        if (!cnt_r[0]) begin
          // low byte of a sample; a lone trailing byte is dropped
          cmd.low_wr = 1'b1;
          cnt_step   = 4'd1;
          if (sts.data_last) begin
            ph_step    = PH_DONE;
            cmd.push_a = 1'b1;
            cmd.desc_a = '{kind: wavhp_pkg::KIND_STATUS,
                           status: wavhp_pkg::ST_OK, last: 1'b1};
          end
        end else begin
          cnt_step   = 4'd0;
          cmd.push_a = 1'b1;
          cmd.desc_a = '{kind: wavhp_pkg::KIND_SAMPLE,
                         status: wavhp_pkg::ST_OK, last: sts.data_last};
          if (sts.data_last) ph_step = PH_DONE;
        end
      end
      default: begin
        // done: bytes ignored until end of file
      end
    endcase

    // early end of file status
    eof_desc.kind = wavhp_pkg::KIND_STATUS;
    eof_desc.last = 1'b1;
    unique case (ph_step)
      PH_RIFF, PH_RSIZE, PH_WAVE: eof_desc.status = wavhp_pkg::ST_BAD_TAG;
      PH_FID, PH_FSKIPLEN, PH_FMTLEN, PH_FSKIP, PH_FMT, PH_FEXTRA:
        eof_desc.status = wavhp_pkg::ST_NO_FMT;
      PH_DID, PH_DSKIPLEN, PH_DATALEN, PH_DSKIP:
        eof_desc.status = wavhp_pkg::ST_NO_DATA;
      default: eof_desc.status = wavhp_pkg::ST_SHORT;
    endcase
    cmd.desc_b = eof_desc;
    cmd.push_b = in_end_of_file && (ph_step != PH_DONE);

    // everything is gated by the input handshake
    if (!fire) cmd = '0;
  end

  // next state, end of file returns to the start
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    if (fire) begin
      if (in_end_of_file) begin
        phase_nxt = PH_RIFF;
        cnt_nxt   = 4'd0;
      end else begin
        phase_nxt = ph_step;
        cnt_nxt   = cnt_step;
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF;
      cnt_r   <= 4'd0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // word and sample counters stay in range for their phase
  a_cnt_word: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_FMT) |-> (cnt_r <= 4'd3))
    else $error("byte counter out of range");

  // commands only on an accepted item
  a_cmd_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_a || cmd.push_b || cmd.shift_en || cmd.dec_data) |-> fire)
    else $error("command without accepted item");

  // end of file always returns to the tag search
  a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_end_of_file) |=> (phase_r == PH_RIFF && cnt_r == 4'd0))
    else $error("no restart after end of file");

endmodule

// File: rtl/wav_header_parser.sv
`timescale 1ns / 1ps
// top level of the byte-serial wav header parser
// depends on wavhp_pkg, wavhp_ctrl, wavhp_datapath (with wavhp_div)
//
//  channel | handshake              | payload
//  input   | in_valid / in_ready    | in_data_byte, in_end_of_file
//  result  | out_valid / out_ready  | out_result_kind .. out_last_result
//
// one byte is taken per cycle while no result is waiting; a byte that
// causes results is followed by no byte until all its results are taken.
// the format item waits in the frame-count divider (one quotient bit per
// cycle) and no byte is taken meanwhile.
// rst_n is synchronous; an output stall holds the queued items and in_ready.

module wav_header_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_end_of_file,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_result_kind,
  output logic [2:0]          out_status_code,
  output logic [15:0]         out_audio_format,
  output logic [15:0]         out_channel_count,
  output logic [31:0]         out_sample_rate,
  output logic [31:0]         out_byte_rate,
  output logic [15:0]         out_block_align,
  output logic [15:0]         out_sample_bits,
  output logic [31:0]         out_data_length,
  output logic [30:0]         out_frame_count,
  output logic signed [15:0]  out_sample_value,
  output logic                out_last_result
);

  wavhp_pkg::cmd_t cmd;
  wavhp_pkg::sts_t sts;

  // phase controller
  wavhp_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_end_of_file (in_end_of_file),
    .sts            (sts),
    .cmd            (cmd)
  );

  // datapath and result queue
  wavhp_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .data_byte         (in_data_byte),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_kind   (out_result_kind),
    .out_status_code   (out_status_code),
    .out_audio_format  (out_audio_format),
    .out_channel_count (out_channel_count),
    .out_sample_rate   (out_sample_rate),
    .out_byte_rate     (out_byte_rate),
    .out_block_align   (out_block_align),
    .out_sample_bits   (out_sample_bits),
    .out_data_length   (out_data_length),
    .out_frame_count   (out_frame_count),
    .out_sample_value  (out_sample_value),
    .out_last_result   (out_last_result)
  );

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// testbench for wav_header_parser: byte streams of wav files in, format/sample/status items out
// depends on wavhp_pkg and the rtl top level; holds its own parser model and a scoreboard

module tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_BYTES   = 1200;
  localparam int HOLD_AT_ITEM   = 1200;
  localparam int HOLD_CYCLES    = 400;

  // extra chunk ids, little-endian
  localparam logic [31:0] TAG_LIST = 32'h5453_494C;
  localparam logic [31:0] TAG_JUNK = 32'h4B4E_554A;

  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_FMT_ID, PH_FMT_SKIPLEN, PH_FMT_LEN, PH_FMT_SKIP,
    PH_FMT_BODY, PH_FMT_EXTRA, PH_DATA_ID, PH_DATA_SKIPLEN, PH_DATA_LEN, PH_DATA_SKIP,
    PH_DATA_BODY, PH_DONE
  } parse_phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [15:0] afmt;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [31:0] brate;
    logic [15:0] align;
    logic [15:0] bits;
    logic [31:0] dlen;
    logic [30:0] frames;
    logic [15:0] pcm;
    logic        last;
  } wav_result_t;

  typedef struct packed {
    logic       drain;
    logic       eof;
    logic [7:0] data;
  } stream_byte_t;

  typedef struct packed {
    logic [31:0] riff;
    logic [31:0] wave;
    logic [31:0] fmt_tag;
    logic [31:0] fmt_len;
    logic [15:0] afmt;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [31:0] brate;
    logic [15:0] align;
    logic [15:0] bits;
    logic [31:0] dlen;
    logic [1:0]  pre;
    logic [1:0]  post;
  } wav_spec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_data_byte = 8'd0;
  logic in_end_of_file = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_result_kind;
  logic [2:0] out_status_code;
  logic [15:0] out_audio_format;
  logic [15:0] out_channel_count;
  logic [31:0] out_sample_rate;
  logic [31:0] out_byte_rate;
  logic [15:0] out_block_align;
  logic [15:0] out_sample_bits;
  logic [31:0] out_data_length;
  logic [30:0] out_frame_count;
  logic signed [15:0] out_sample_value;
  logic out_last_result;

  wav_header_parser uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_data_byte(in_data_byte), .in_end_of_file(in_end_of_file),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_kind(out_result_kind), .out_status_code(out_status_code),
    .out_audio_format(out_audio_format), .out_channel_count(out_channel_count),
    .out_sample_rate(out_sample_rate), .out_byte_rate(out_byte_rate),
    .out_block_align(out_block_align), .out_sample_bits(out_sample_bits),
    .out_data_length(out_data_length), .out_frame_count(out_frame_count),
    .out_sample_value(out_sample_value), .out_last_result(out_last_result)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser model state
  parse_phase_t phase;
  logic [4:0]   byte_cnt;
  logic [31:0]  word_sr, chunk_len, skip_left, data_left;
  logic [15:0]  h_fmt, h_chans, h_align, h_bits;
  logic [31:0]  h_rate, h_brate;
  logic [7:0]   low_byte;

  wav_result_t  expected_q[$];
  stream_byte_t byte_q[$];
  logic [7:0]   file_buf[$];
  int n_in = 0;
  int n_err = 0;
  int bytes_made = 0;

  // ---------------------------------------------------------------
  // parser model

  function automatic void clear_parser();
    phase = PH_RIFF;
    byte_cnt = '0;
    word_sr = '0;
    chunk_len = '0;
    skip_left = '0;
    data_left = '0;
    h_fmt = '0;
    h_chans = '0;
    h_rate = '0;
    h_brate = '0;
    h_align = '0;
    h_bits = '0;
    low_byte = '0;
  endfunction

  function automatic void queue_result(logic [1:0] kind, logic [2:0] status,
                                       logic [15:0] pcm, logic last);
    wav_result_t r;
    r = '0;
    r.kind = kind;
    r.status = status;
    r.last = last;
    if (kind == wavhp_pkg::KIND_FORMAT) begin
      r.afmt = h_fmt;
      r.chans = h_chans;
      r.rate = h_rate;
      r.brate = h_brate;
      r.align = h_align;
      r.bits = h_bits;
      r.dlen = chunk_len;
      r.frames = (h_chans == 16'd0) ? '0 : 31'((chunk_len >> 1) / {16'd0, h_chans});
    end
    if (kind == wavhp_pkg::KIND_SAMPLE) r.pcm = pcm;
    expected_q.push_back(r);
  endfunction

  // little-endian word assembly, true on the fourth byte
  function automatic bit take_word(logic [7:0] b);
    word_sr = {b, word_sr[31:8]};
    byte_cnt = byte_cnt + 5'd1;
    if (byte_cnt >= 5'd4) begin
      byte_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // sample size check once the whole fmt chunk is in
  function automatic void fmt_complete();
    if (h_bits != wavhp_pkg::BITS_16) begin
      phase = PH_DONE;
      queue_result(wavhp_pkg::KIND_STATUS, wavhp_pkg::ST_NOT_16, '0, 1'b1);
    end else begin
      phase = PH_DATA_ID;
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic eof);
    int k;
    logic [2:0] code;
    case (phase)
      PH_RIFF, PH_WAVE: begin
        if (take_word(b)) begin
          if (word_sr != ((phase == PH_RIFF) ? wavhp_pkg::TAG_RIFF : wavhp_pkg::TAG_WAVE))
          begin
            phase = PH_DONE;
            queue_result(wavhp_pkg::KIND_STATUS, wavhp_pkg::ST_BAD_TAG, '0, 1'b1);
          end else begin
            phase = (phase == PH_RIFF) ? PH_RSIZE : PH_FMT_ID;
          end
        end
      end
      PH_RSIZE: begin
        if (take_word(b)) phase = PH_WAVE;
      end
      PH_FMT_ID: begin
        if (take_word(b))
          phase = (word_sr == wavhp_pkg::TAG_FMT) ? PH_FMT_LEN : PH_FMT_SKIPLEN;
      end
      PH_DATA_ID: begin
        if (take_word(b))
          phase = (word_sr == wavhp_pkg::TAG_DATA) ? PH_DATA_LEN : PH_DATA_SKIPLEN;
      end
      PH_FMT_SKIPLEN: begin
        if (take_word(b)) begin
          skip_left = word_sr;
          phase = (word_sr == '0) ? PH_FMT_ID : PH_FMT_SKIP;
        end
      end
      PH_DATA_SKIPLEN: begin
        if (take_word(b)) begin
          skip_left = word_sr;
          phase = (word_sr == '0) ? PH_DATA_ID : PH_DATA_SKIP;
        end
      end
      PH_FMT_SKIP: begin
        skip_left = skip_left - 32'd1;
        if (skip_left == '0) phase = PH_FMT_ID;
      end
      PH_DATA_SKIP: begin
        skip_left = skip_left - 32'd1;
        if (skip_left == '0) phase = PH_DATA_ID;
      end
      PH_FMT_LEN: begin
        if (take_word(b)) begin
          chunk_len = word_sr;
          phase = PH_FMT_BODY;
        end
      end
      PH_FMT_BODY: begin
        // 16 field bytes are always taken, whatever the chunk length says
        k = int'(byte_cnt[3:0]);
        if (k < 2) h_fmt = h_fmt | (16'(b) << (8 * k));
        else if (k < 4) h_chans = h_chans | (16'(b) << (8 * (k - 2)));
        else if (k < 8) h_rate = h_rate | (32'(b) << (8 * (k - 4)));
        else if (k < 12) h_brate = h_brate | (32'(b) << (8 * (k - 8)));
        else if (k < 14) h_align = h_align | (16'(b) << (8 * (k - 12)));
        else h_bits = h_bits | (16'(b) << (8 * (k - 14)));
        byte_cnt = byte_cnt + 5'd1;
        if (byte_cnt >= 5'd16) begin
          byte_cnt = '0;
          if (chunk_len > wavhp_pkg::FMT_BYTES) begin
            skip_left = chunk_len - wavhp_pkg::FMT_BYTES;
            phase = PH_FMT_EXTRA;
          end else begin
            fmt_complete();
          end
        end
      end
      PH_FMT_EXTRA: begin
        skip_left = skip_left - 32'd1;
        if (skip_left == '0) fmt_complete();
      end
      PH_DATA_LEN: begin
        if (take_word(b)) begin
          chunk_len = word_sr;
          data_left = word_sr;
          if (data_left == '0) begin
            phase = PH_DONE;
            queue_result(wavhp_pkg::KIND_FORMAT, wavhp_pkg::ST_OK, '0, 1'b1);
          end else begin
            phase = PH_DATA_BODY;
            queue_result(wavhp_pkg::KIND_FORMAT, wavhp_pkg::ST_OK, '0, 1'b0);
          end
        end
      end
      PH_DATA_BODY: begin
        data_left = data_left - 32'd1;
        if (!byte_cnt[0]) begin
          // low byte; a lone trailing byte is dropped with an ok status
          low_byte = b;
          byte_cnt = 5'd1;
          if (data_left == '0) begin
            phase = PH_DONE;
            queue_result(wavhp_pkg::KIND_STATUS, wavhp_pkg::ST_OK, '0, 1'b1);
          end
        end else begin
          byte_cnt = '0;
          queue_result(wavhp_pkg::KIND_SAMPLE, wavhp_pkg::ST_OK, {b, low_byte},
                       data_left == '0);
          if (data_left == '0) phase = PH_DONE;
        end
      end
      default: ;
    endcase

    // early end of file gives a status by where parsing stopped
    if (eof) begin
      if (phase != PH_DONE) begin
        if (phase <= PH_WAVE) code = wavhp_pkg::ST_BAD_TAG;
        else if (phase <= PH_FMT_EXTRA) code = wavhp_pkg::ST_NO_FMT;
        else if (phase <= PH_DATA_SKIP) code = wavhp_pkg::ST_NO_DATA;
        else code = wavhp_pkg::ST_SHORT;
        queue_result(wavhp_pkg::KIND_STATUS, code, '0, 1'b1);
      end
      clear_parser();
    end
  endfunction

  // ---------------------------------------------------------------
  // file builders

  task automatic put_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) file_buf.push_back(w[8 * i +: 8]);
  endtask

  task automatic put_half(logic [15:0] h);
    file_buf.push_back(h[7:0]);
    file_buf.push_back(h[15:8]);
  endtask

  task automatic put_noise(int n);
    repeat (n) file_buf.push_back(8'($urandom));
  endtask

  // a chunk to be skipped, sometimes carrying an id that is out of place
  task automatic put_junk(bit after_fmt);
    logic [31:0] tag;
    int len;
    case ($urandom_range(0, 3))
      0: tag = TAG_LIST;
      1: tag = after_fmt ? wavhp_pkg::TAG_FMT : wavhp_pkg::TAG_DATA;
      2: tag = TAG_JUNK;
      default: tag = $urandom;
    endcase
    len = $urandom_range(0, 6);
    put_word(tag);
    put_word(len);
    put_noise(len);
  endtask

  // everything up to and including the data length word
  task automatic put_wav_head(wav_spec_t s);
    put_word(s.riff);
    put_word($urandom);
    put_word(s.wave);
    repeat (s.pre) put_junk(1'b0);
    put_word(s.fmt_tag);
    put_word(s.fmt_len);
    put_half(s.afmt);
    put_half(s.chans);
    put_word(s.rate);
    put_word(s.brate);
    put_half(s.align);
    put_half(s.bits);
    if (s.fmt_len > wavhp_pkg::FMT_BYTES) put_noise(int'(s.fmt_len) - 16);
    repeat (s.post) put_junk(1'b1);
    put_word(wavhp_pkg::TAG_DATA);
    put_word(s.dlen);
  endtask

  // move the file to the send queue, cut to keep bytes when keep is nonzero
  task automatic emit_file(int keep, bit drain);
    stream_byte_t s;
    int n;
    n = (keep > 0 && keep < file_buf.size()) ? keep : file_buf.size();
    for (int i = 0; i < n; i++) begin
      s.data = file_buf[i];
      s.eof = (i == n - 1);
      s.drain = drain && (i == 0);
      byte_q.push_back(s);
    end
    bytes_made += n;
    file_buf.delete();
  endtask

  function automatic wav_spec_t plain_spec();
    wav_spec_t s;
    s.riff = wavhp_pkg::TAG_RIFF;
    s.wave = wavhp_pkg::TAG_WAVE;
    s.fmt_tag = wavhp_pkg::TAG_FMT;
    s.fmt_len = wavhp_pkg::FMT_BYTES;
    s.afmt = 16'd1;
    s.chans = 16'd2;
    s.rate = 32'd44100;
    s.brate = 32'd176400;
    s.align = 16'd4;
    s.bits = wavhp_pkg::BITS_16;
    s.dlen = 32'd4;
    s.pre = '0;
    s.post = '0;
    return s;
  endfunction

  // idling phase follows the number of items taken
  function automatic int idle_mode();
    return (n_in / 300) % 4;
  endfunction

  function automatic string show(wav_result_t r);
    return $sformatf({"kind %0d status %0d fmt %h ch %h rate %h brate %h align %h",
                      " bits %h len %h frames %h pcm %h last %b"},
                     r.kind, r.status, r.afmt, r.chans, r.rate, r.brate, r.align,
                     r.bits, r.dlen, r.frames, r.pcm, r.last);
  endfunction

  // ---------------------------------------------------------------
  // byte driver, model updated on each accepted item
  always @(posedge clk) begin : drive
    stream_byte_t nxt;
    int idle_pct;
    if (!rst_n) begin
      clear_parser();
      expected_q.delete();
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(in_data_byte, in_end_of_file);
        n_in++;
      end
      if (!in_valid || in_ready) begin
        idle_pct = (idle_mode() == 1) ? 49 : (idle_mode() == 3) ? 10 : 0;
        // a drain-marked file waits until all results are back
        if (byte_q.size() != 0 && !(byte_q[0].drain && expected_q.size() != 0) &&
            $urandom_range(0, 99) >= idle_pct) begin
          nxt = byte_q.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= nxt.data;
          in_end_of_file <= nxt.eof;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result checker and receiver stalls
  int  hold_left = 0;
  bit  held = 1'b0;

  always @(posedge clk) begin : watch
    wav_result_t seen, want;
    string diff;
    int stall_pct;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen = {out_result_kind, out_status_code, out_audio_format, out_channel_count,
                out_sample_rate, out_byte_rate, out_block_align, out_sample_bits,
                out_data_length, out_frame_count, out_sample_value, out_last_result};
        if (expected_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected item: %s", show(seen));
        end else begin
          want = expected_q.pop_front();
          diff = "";
          if (seen.kind !== want.kind) diff = {diff, " kind"};
          if (seen.status !== want.status) diff = {diff, " status"};
          if (seen.afmt !== want.afmt) diff = {diff, " audio_format"};
          if (seen.chans !== want.chans) diff = {diff, " channel_count"};
          if (seen.rate !== want.rate) diff = {diff, " sample_rate"};
          if (seen.brate !== want.brate) diff = {diff, " byte_rate"};
          if (seen.align !== want.align) diff = {diff, " block_align"};
          if (seen.bits !== want.bits) diff = {diff, " sample_bits"};
          if (seen.dlen !== want.dlen) diff = {diff, " data_length"};
          if (seen.frames !== want.frames) diff = {diff, " frame_count"};
          if (seen.pcm !== want.pcm) diff = {diff, " sample_value"};
          if (seen.last !== want.last) diff = {diff, " last_result"};
          if (diff != "") begin
            n_err++;
            if (n_err <= 10) begin
              $display("mismatch in%s", diff);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(seen));
            end
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held && n_in >= HOLD_AT_ITEM) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        stall_pct = (idle_mode() == 2) ? 49 : (idle_mode() == 3) ? 10 : 0;
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // watchdog on cycles with no item moving
  initial begin : dog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // stimulus and end of run
  initial begin : main
    wav_spec_t sp;
    int pick, keep, files, base;

    // plain stereo file with sample extremes
    sp = plain_spec();
    sp.dlen = 32'd8;
    put_wav_head(sp);
    put_half(16'h8000);
    put_half(16'h7FFF);
    put_half(16'h0000);
    put_half(16'hFFFF);
    emit_file(0, 1'b0);

    // bad riff tag, trailing bytes ignored
    sp = plain_spec();
    sp.riff = 32'h5846_4952;
    put_wav_head(sp);
    emit_file(8, 1'b0);

    // bad riff tag with end of file on the failing byte
    put_wav_head(sp);
    emit_file(4, 1'b0);

    // bad wave tag
    sp = plain_spec();
    sp.wave = wavhp_pkg::TAG_WAVE ^ 32'h0100_0000;
    put_wav_head(sp);
    emit_file(14, 1'b0);

    // short fmt chunk, mono
    sp = plain_spec();
    sp.fmt_len = 32'd8;
    sp.chans = 16'd1;
    sp.dlen = 32'd2;
    put_wav_head(sp);
    put_noise(2);
    emit_file(0, 1'b0);

    // extra fmt bytes and chunks to skip on both sides
    sp = plain_spec();
    sp.fmt_len = 32'd20;
    sp.pre = 2'd3;
    sp.post = 2'd3;
    put_wav_head(sp);
    put_noise(4);
    emit_file(0, 1'b0);

    // 8-bit samples rejected after the extra bytes
    sp = plain_spec();
    sp.fmt_len = 32'd18;
    sp.bits = 16'd8;
    put_wav_head(sp);
    put_noise(4);
    emit_file(0, 1'b0);

    // sample size wrong only in its high byte
    sp = plain_spec();
    sp.bits = 16'h0110;
    put_wav_head(sp);
    emit_file(0, 1'b0);

    // empty data chunk, tail ignored
    sp = plain_spec();
    sp.dlen = 32'd0;
    put_wav_head(sp);
    put_noise(3);
    emit_file(0, 1'b0);

    // odd data length drops the last byte
    sp = plain_spec();
    sp.dlen = 32'd3;
    put_wav_head(sp);
    put_noise(3);
    emit_file(0, 1'b0);

    // zero channels gives zero frames
    sp = plain_spec();
    sp.chans = 16'd0;
    sp.dlen = 32'd6;
    put_wav_head(sp);
    put_noise(6);
    emit_file(0, 1'b0);

    // all fields but the sample size at their maximum, file ends on a completed sample
    sp = plain_spec();
    sp.afmt = 16'hFFFF;
    sp.chans = 16'hFFFF;
    sp.rate = 32'hFFFF_FFFF;
    sp.brate = 32'hFFFF_FFFF;
    sp.align = 16'hFFFF;
    sp.dlen = 32'hFFFF_FFFF;
    put_wav_head(sp);
    file_buf.push_back(8'h00);
    file_buf.push_back(8'hFF);
    file_buf.push_back(8'hFF);
    file_buf.push_back(8'h00);
    emit_file(0, 1'b0);

    // file ends on a low byte inside the data
    sp = plain_spec();
    sp.dlen = 32'd10;
    put_wav_head(sp);
    put_noise(3);
    emit_file(0, 1'b0);

    // file ends right on the data length word
    sp = plain_spec();
    sp.chans = 16'd3;
    sp.dlen = 32'h7FFF_FFFF;
    put_wav_head(sp);
    emit_file(0, 1'b0);

    // early ends: riff size, fmt id, fmt fields, data id, data length, riff tag
    sp = plain_spec();
    put_wav_head(sp);
    emit_file(6, 1'b0);
    put_wav_head(sp);
    emit_file(14, 1'b0);
    put_wav_head(sp);
    emit_file(30, 1'b0);
    put_wav_head(sp);
    emit_file(38, 1'b0);
    put_wav_head(sp);
    emit_file(42, 1'b0);
    put_wav_head(sp);
    emit_file(1, 1'b0);

    // early end inside the extra fmt bytes
    sp.fmt_len = 32'd24;
    put_wav_head(sp);
    emit_file(40, 1'b0);

    // random files: mostly well formed, some cut short, corrupted or noise
    base = bytes_made;
    files = 0;
    while (bytes_made - base < RANDOM_BYTES) begin
      sp = plain_spec();
      sp.pre = 2'($urandom_range(0, 2));
      sp.post = 2'($urandom_range(0, 2));
      sp.afmt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'd1;
      sp.chans = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
      sp.rate = $urandom;
      sp.brate = $urandom;
      sp.align = 16'($urandom);
      sp.bits = ($urandom_range(0, 9) == 0) ? 16'($urandom) : wavhp_pkg::BITS_16;
      case ($urandom_range(0, 5))
        0: sp.fmt_len = $urandom_range(0, 15);
        1: sp.fmt_len = $urandom_range(17, 24);
        default: sp.fmt_len = wavhp_pkg::FMT_BYTES;
      endcase
      sp.dlen = $urandom_range(0, 24);
      pick = $urandom_range(0, 99);
      keep = 0;
      if (pick >= 93) begin
        if ($urandom_range(0, 1) == 1) put_word(wavhp_pkg::TAG_RIFF);
        put_noise($urandom_range(1, 12));
      end else begin
        if (pick >= 85) begin
          case ($urandom_range(0, 2))
            0: sp.riff = sp.riff ^ (32'd1 << $urandom_range(0, 31));
            1: sp.wave = sp.wave ^ (32'd1 << $urandom_range(0, 31));
            default: sp.fmt_tag = sp.fmt_tag ^ (32'd1 << $urandom_range(0, 31));
          endcase
        end
        put_wav_head(sp);
        put_noise(int'(sp.dlen) + $urandom_range(0, 2));
        if (pick >= 70 && pick < 85) keep = $urandom_range(1, file_buf.size());
      end
      emit_file(keep, (files % 8) == 0);
      files++;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (n_err == 0 && expected_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// File: filelist.f
rtl/wavhp_pkg.sv
rtl/wavhp_div.sv
rtl/wavhp_datapath.sv
rtl/wavhp_ctrl.sv
rtl/wav_header_parser.sv
test/tb.sv
